// ----- rtl/core/svg_pkg.sv -----
`default_nettype none

package svg_pkg;

   localparam int unsigned LANES = 2;
   localparam int unsigned LANE_ROW = 0;
   localparam int unsigned LANE_COL = 1;

   localparam logic [7:0] MAX_PRECISION = 8'd255;
   localparam logic [7:0] PRECISION_RESET = 8'd48;
   localparam int unsigned COORD_FRAC_BITS = 15;
   localparam int unsigned CORDIC_FRAC_BITS = 30;
   localparam int unsigned PROD_FRAC_BITS = 2 * CORDIC_FRAC_BITS;

   localparam int unsigned INT_BITS = 8;
   localparam int unsigned ANGLE_BITS = 32;
   localparam int unsigned DIV_STEPS = INT_BITS + ANGLE_BITS;
   localparam int unsigned QUO_W = DIV_STEPS;
   localparam int unsigned TEX_FRAC_BITS = 16;
   localparam int unsigned TEX_STEP = INT_BITS + TEX_FRAC_BITS - 1;
   localparam int unsigned ANG_STEP_ROW = INT_BITS + ANGLE_BITS - 2;

   localparam int unsigned CORDIC_STEPS = 30;
   localparam int unsigned XY_W = 33;
   localparam int unsigned PROD_W = 2 * XY_W;
   localparam logic signed [XY_W-1:0] CORDIC_X0 = 33'sd652032874;

   localparam logic [1:0] QUAD_0 = 2'd0;
   localparam logic [1:0] QUAD_1 = 2'd1;
   localparam logic [1:0] QUAD_2 = 2'd2;

   typedef struct packed {
      logic [5:0][15:0] tri_idx;
      logic             cell_valid;
      logic [16:0]      tex_u;
      logic [16:0]      tex_v;
   } meta_type;

   typedef struct packed {
      logic [7:0]       num;
      logic [7:0]       rem;
      logic [QUO_W-1:0] quo;
      logic             rnd_tex;
      logic             rnd_ang;
   } div_lane_type;

   typedef struct packed {
      meta_type                      meta;
      logic [7:0]                    p;
      logic [7:0]                    h;
      div_lane_type [LANES-1:0]      lane;
   } div_type;

   typedef struct packed {
      logic signed [XY_W-1:0] x;
      logic signed [XY_W-1:0] y;
      logic signed [31:0]     z;
      logic [1:0]             quad;
   } cordic_lane_type;

   typedef struct packed {
      meta_type                    meta;
      cordic_lane_type [LANES-1:0] lane;
   } cordic_type;

   function automatic logic signed [31:0] turn_atan(input int unsigned k);
      logic signed [31:0] a;
      case (k)
         0:  a = 32'sd536870912;
         1:  a = 32'sd316933406;
         2:  a = 32'sd167458907;
         3:  a = 32'sd85004756;
         4:  a = 32'sd42667331;
         5:  a = 32'sd21354465;
         6:  a = 32'sd10679838;
         7:  a = 32'sd5340245;
         8:  a = 32'sd2670163;
         9:  a = 32'sd1335087;
         10: a = 32'sd667544;
         11: a = 32'sd333772;
         12: a = 32'sd166886;
         13: a = 32'sd83443;
         14: a = 32'sd41722;
         15: a = 32'sd20861;
         16: a = 32'sd10430;
         17: a = 32'sd5215;
         18: a = 32'sd2608;
         19: a = 32'sd1304;
         20: a = 32'sd652;
         21: a = 32'sd326;
         22: a = 32'sd163;
         23: a = 32'sd81;
         24: a = 32'sd41;
         25: a = 32'sd20;
         26: a = 32'sd10;
         27: a = 32'sd5;
         28: a = 32'sd3;
         29: a = 32'sd1;
         default: a = 32'sd0;
      endcase
      return a;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/uv_sphere_vertex_generator_core.sv -----
// Channel   Direction  Handshake              Transaction
// req_      in         req_valid/req_ready    one grid point (row, column)
// rsp_      out        rsp_valid/rsp_ready    position, texture coords, cell indices
// csr_      in         csr_valid/csr_ready    precision write
//
// One transaction per cycle sustained while rsp_ready stays high; the chain is 40
// long-division cells, 30 CORDIC cells, a multiply stage and an output register.
// Each cell holds its transaction until the cell ahead frees up, so bubbles
// close up and a stalled rsp_ fills the chain before req_ready drops.
// Reset is synchronous; it clears the cell valids and sets precision to 48.
`default_nettype none

module uv_sphere_vertex_generator_core (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire logic [7:0]   req_row,
   input  wire logic [7:0]   req_column,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output logic signed [15:0] rsp_pos_x,
   output logic signed [15:0] rsp_pos_y,
   output logic signed [15:0] rsp_pos_z,
   output logic [16:0]       rsp_tex_u,
   output logic [16:0]       rsp_tex_v,
   output logic [15:0]       rsp_tri_a0,
   output logic [15:0]       rsp_tri_a1,
   output logic [15:0]       rsp_tri_a2,
   output logic [15:0]       rsp_tri_b0,
   output logic [15:0]       rsp_tri_b1,
   output logic [15:0]       rsp_tri_b2,
   output logic              rsp_cell_valid,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [7:0]   csr_precision
);
   import svg_pkg::*;

   localparam int unsigned PROD_SHIFT = PROD_FRAC_BITS - COORD_FRAC_BITS;
   localparam int unsigned Y_SHIFT = CORDIC_FRAC_BITS - COORD_FRAC_BITS;

   function automatic logic [15:0] round_sat(input logic signed [PROD_W-1:0] v,
                                             input int unsigned sh);
      logic signed [PROD_W-1:0] r;
      logic [15:0]              o;
      r = (v + (PROD_W'(1) <<< (sh - 1))) >>> sh;
      if (r > PROD_W'(32767)) begin
         o = 16'h7fff;
      end else if (r < -PROD_W'(32768)) begin
         o = 16'h8000;
      end else begin
         o = r[15:0];
      end
      return o;
   endfunction

   function automatic logic [16:0] tex_sat(input logic [QUO_W-1:0] q, input logic rnd);
      logic [24:0] t;
      t = {1'b0, q[QUO_W-1:TEX_FRAC_BITS]} + {24'd0, rnd};
      return (t > 25'd65536) ? 17'h10000 : t[16:0];
   endfunction

   logic [7:0] precision_ff;
   logic [7:0] p_eff;

   div_type    div_head;
   div_type    div_data  [0:DIV_STEPS];
   logic       div_valid [0:DIV_STEPS];
   logic       div_adv   [0:DIV_STEPS];

   cordic_type cor_data  [0:CORDIC_STEPS];
   logic       cor_valid [0:CORDIC_STEPS];
   logic       cor_adv   [0:CORDIC_STEPS];

   logic [15:0] top_idx;
   logic [15:0] bot_idx;
   logic [8:0]  w;
   logic        in_cell;
   logic [31:0] ang [LANES];
   logic [31:0] ang_sum;
   logic [31:0] ang_res;

   logic signed [XY_W-1:0] c_v [LANES];
   logic signed [XY_W-1:0] s_v [LANES];
   logic signed [XY_W-1:0] st_abs;

   logic                     mul_valid_ff;
   meta_type                 mul_meta_ff;
   logic signed [PROD_W-1:0] px_ff;
   logic signed [PROD_W-1:0] pz_ff;
   logic signed [PROD_W-1:0] ny_ff;
   logic                     mul_adv;
   logic                     rsp_adv;

   logic rsp_valid_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         precision_ff <= PRECISION_RESET;
      end else if (csr_valid && csr_ready) begin
         precision_ff <= csr_precision;
      end
   end

   always_comb begin
      if (precision_ff == 8'd0) begin
         p_eff = 8'd1;
      end else if (precision_ff > MAX_PRECISION) begin
         p_eff = MAX_PRECISION;
      end else begin
         p_eff = precision_ff;
      end
      w = {1'b0, p_eff} + 9'd1;
      in_cell = (req_row < p_eff) && (req_column < p_eff);
      top_idx = 16'(17'(req_row) * 17'(w) + 17'(req_column));
      bot_idx = top_idx + 16'(w);

      div_head = '0;
      div_head.p = p_eff;
      div_head.h = {1'b0, p_eff[7:1]};
      div_head.lane[LANE_ROW].num = req_row;
      div_head.lane[LANE_COL].num = req_column;
      div_head.meta.cell_valid = in_cell;
      if (in_cell) begin
         div_head.meta.tri_idx[0] = top_idx;
         div_head.meta.tri_idx[1] = top_idx + 16'd1;
         div_head.meta.tri_idx[2] = bot_idx;
         div_head.meta.tri_idx[3] = top_idx + 16'd1;
         div_head.meta.tri_idx[4] = bot_idx + 16'd1;
         div_head.meta.tri_idx[5] = bot_idx;
      end
   end

   assign div_data[0] = div_head;
   assign div_valid[0] = req_valid;
   assign req_ready = div_adv[0];

   for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
      svg_div_cell #(.STEP(g)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (div_valid[g]),
         .in_data   (div_data[g]),
         .adv_out   (div_adv[g]),
         .adv_in    (div_adv[g+1]),
         .out_valid (div_valid[g+1]),
         .out_data  (div_data[g+1])
      );
   end

   always_comb begin
      ang[LANE_ROW] = div_data[DIV_STEPS].lane[LANE_ROW].quo[32:1]
                    + {31'd0, div_data[DIV_STEPS].lane[LANE_ROW].rnd_ang};
      ang[LANE_COL] = div_data[DIV_STEPS].lane[LANE_COL].quo[31:0]
                    + {31'd0, div_data[DIV_STEPS].lane[LANE_COL].rnd_ang};
      cor_data[0] = '0;
      cor_data[0].meta = div_data[DIV_STEPS].meta;
      cor_data[0].meta.tex_v = tex_sat(div_data[DIV_STEPS].lane[LANE_ROW].quo,
                                       div_data[DIV_STEPS].lane[LANE_ROW].rnd_tex);
      cor_data[0].meta.tex_u = tex_sat(div_data[DIV_STEPS].lane[LANE_COL].quo,
                                       div_data[DIV_STEPS].lane[LANE_COL].rnd_tex);
      ang_sum = '0;
      ang_res = '0;
      for (int l = 0; l < LANES; l++) begin
         ang_sum = ang[l] + 32'h2000_0000;
         ang_res = ang[l] - {ang_sum[31:30], 30'd0};
         cor_data[0].lane[l].quad = ang_sum[31:30];
         cor_data[0].lane[l].z = signed'(ang_res);
         cor_data[0].lane[l].x = CORDIC_X0;
         cor_data[0].lane[l].y = '0;
      end
   end

   assign cor_valid[0] = div_valid[DIV_STEPS];
   assign div_adv[DIV_STEPS] = cor_adv[0];

   for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
      svg_cordic_cell #(.STEP(g)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (cor_valid[g]),
         .in_data   (cor_data[g]),
         .adv_out   (cor_adv[g]),
         .adv_in    (cor_adv[g+1]),
         .out_valid (cor_valid[g+1]),
         .out_data  (cor_data[g+1])
      );
   end

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         case (cor_data[CORDIC_STEPS].lane[l].quad)
            QUAD_0: begin
               c_v[l] = cor_data[CORDIC_STEPS].lane[l].x;
               s_v[l] = cor_data[CORDIC_STEPS].lane[l].y;
            end
            QUAD_1: begin
               c_v[l] = -cor_data[CORDIC_STEPS].lane[l].y;
               s_v[l] = cor_data[CORDIC_STEPS].lane[l].x;
            end
            QUAD_2: begin
               c_v[l] = -cor_data[CORDIC_STEPS].lane[l].x;
               s_v[l] = -cor_data[CORDIC_STEPS].lane[l].y;
            end
            default: begin
               c_v[l] = cor_data[CORDIC_STEPS].lane[l].y;
               s_v[l] = -cor_data[CORDIC_STEPS].lane[l].x;
            end
         endcase
      end
      st_abs = s_v[LANE_ROW][XY_W-1] ? -s_v[LANE_ROW] : s_v[LANE_ROW];
   end

   assign rsp_adv = !rsp_valid_ff || rsp_ready;
   assign mul_adv = !mul_valid_ff || rsp_adv;
   assign cor_adv[CORDIC_STEPS] = mul_adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
      end else if (mul_adv) begin
         mul_valid_ff <= cor_valid[CORDIC_STEPS];
      end
      if (mul_adv) begin
         mul_meta_ff <= cor_data[CORDIC_STEPS].meta;
         px_ff <= c_v[LANE_COL] * st_abs;
         pz_ff <= s_v[LANE_COL] * st_abs;
         ny_ff <= PROD_W'(-c_v[LANE_ROW]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_adv) begin
         rsp_valid_ff <= mul_valid_ff;
      end
      if (rsp_adv) begin
         rsp_pos_x <= round_sat(-px_ff, PROD_SHIFT);
         rsp_pos_y <= round_sat(ny_ff, Y_SHIFT);
         rsp_pos_z <= round_sat(pz_ff, PROD_SHIFT);
         rsp_tex_u <= mul_meta_ff.tex_u;
         rsp_tex_v <= mul_meta_ff.tex_v;
         rsp_tri_a0 <= mul_meta_ff.tri_idx[0];
         rsp_tri_a1 <= mul_meta_ff.tri_idx[1];
         rsp_tri_a2 <= mul_meta_ff.tri_idx[2];
         rsp_tri_b0 <= mul_meta_ff.tri_idx[3];
         rsp_tri_b1 <= mul_meta_ff.tri_idx[4];
         rsp_tri_b2 <= mul_meta_ff.tri_idx[5];
         rsp_cell_valid <= mul_meta_ff.cell_valid;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// ----- rtl/core/svg_div_cell.sv -----
`default_nettype none

module svg_div_cell #(
   parameter int unsigned STEP = 0
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            in_valid,
   input  wire svg_pkg::div_type in_data,
   output logic                 adv_out,
   input  wire logic            adv_in,
   output logic                 out_valid,
   output svg_pkg::div_type     out_data
);
   import svg_pkg::*;

   logic    valid_ff;
   div_type data_ff;
   div_type data_in;
   logic [8:0] wide;
   logic [8:0] diff;
   logic [8:0] chk;
   logic [7:0] rem_n;
   logic       ge;

   always_comb begin
      data_in = in_data;
      wide = '0;
      diff = '0;
      chk = '0;
      rem_n = '0;
      ge = 1'b0;
      for (int l = 0; l < LANES; l++) begin
         wide = {in_data.lane[l].rem, in_data.lane[l].num[7]};
         ge = wide >= {1'b0, in_data.p};
         diff = wide - {1'b0, in_data.p};
         rem_n = ge ? diff[7:0] : wide[7:0];
         chk = {1'b0, rem_n} + {1'b0, in_data.h};
         data_in.lane[l].num = {in_data.lane[l].num[6:0], 1'b0};
         data_in.lane[l].rem = rem_n;
         data_in.lane[l].quo = {in_data.lane[l].quo[QUO_W-2:0], ge};
         if (STEP == TEX_STEP) begin
            data_in.lane[l].rnd_tex = chk >= {1'b0, in_data.p};
         end
         if (int'(STEP) == int'(ANG_STEP_ROW) + l) begin
            data_in.lane[l].rnd_ang = chk >= {1'b0, in_data.p};
         end
      end
   end

   assign adv_out = !valid_ff || adv_in;
   assign out_valid = valid_ff;
   assign out_data = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv_out) begin
         valid_ff <= in_valid;
      end
      if (adv_out) begin
         data_ff <= data_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/svg_cordic_cell.sv -----
`default_nettype none

module svg_cordic_cell #(
   parameter int unsigned STEP = 0
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            in_valid,
   input  wire svg_pkg::cordic_type in_data,
   output logic                 adv_out,
   input  wire logic            adv_in,
   output logic                 out_valid,
   output svg_pkg::cordic_type  out_data
);
   import svg_pkg::*;

   logic       valid_ff;
   cordic_type data_ff;
   cordic_type data_in;
   logic signed [XY_W-1:0] xv;
   logic signed [XY_W-1:0] yv;
   logic signed [XY_W-1:0] dx;
   logic signed [XY_W-1:0] dy;
   logic signed [31:0]     zv;

   always_comb begin
      data_in = in_data;
      xv = '0;
      yv = '0;
      dx = '0;
      dy = '0;
      zv = '0;
      for (int l = 0; l < LANES; l++) begin
         xv = in_data.lane[l].x;
         yv = in_data.lane[l].y;
         zv = in_data.lane[l].z;
         dx = yv >>> STEP;
         dy = xv >>> STEP;
         if (!zv[31]) begin
            data_in.lane[l].x = xv - dx;
            data_in.lane[l].y = yv + dy;
            data_in.lane[l].z = zv - turn_atan(STEP);
         end else begin
            data_in.lane[l].x = xv + dx;
            data_in.lane[l].y = yv - dy;
            data_in.lane[l].z = zv + turn_atan(STEP);
         end
      end
   end

   assign adv_out = !valid_ff || adv_in;
   assign out_valid = valid_ff;
   assign out_data = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv_out) begin
         valid_ff <= in_valid;
      end
      if (adv_out) begin
         data_ff <= data_in;
      end
   end

endmodule

`default_nettype wire

// ----- tb/sphere_vertex_checker.sv -----
`timescale 1ns / 100ps

module sphere_vertex_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_ready,
   input  wire logic [7:0]  req_row,
   input  wire logic [7:0]  req_column,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_ready,
   input  wire logic [15:0] rsp_pos_x,
   input  wire logic [15:0] rsp_pos_y,
   input  wire logic [15:0] rsp_pos_z,
   input  wire logic [16:0] rsp_tex_u,
   input  wire logic [16:0] rsp_tex_v,
   input  wire logic [15:0] rsp_tri_a0,
   input  wire logic [15:0] rsp_tri_a1,
   input  wire logic [15:0] rsp_tri_a2,
   input  wire logic [15:0] rsp_tri_b0,
   input  wire logic [15:0] rsp_tri_b1,
   input  wire logic [15:0] rsp_tri_b2,
   input  wire logic        rsp_cell_valid,
   input  wire logic        csr_valid,
   input  wire logic        csr_ready,
   input  wire logic [7:0]  csr_precision,
   output int               errors,
   output int               pending,
   output int               checked
);
   import svg_pkg::*;

   typedef struct packed {
      logic [15:0] pos_x;
      logic [15:0] pos_y;
      logic [15:0] pos_z;
      logic [16:0] tex_u;
      logic [16:0] tex_v;
      logic [15:0] a0;
      logic [15:0] a1;
      logic [15:0] a2;
      logic [15:0] b0;
      logic [15:0] b1;
      logic [15:0] b2;
      logic        cell_valid;
   } vertex_type;

   localparam longint ARC_TURN[30] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
      41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
      10, 5, 3, 1};

   logic [7:0] divisions;
   vertex_type vertex_due[$];

   task automatic rotate_turn(input logic [31:0] a, output longint c, output longint s);
      logic [1:0]  q;
      logic [31:0] r;
      longint      x, y, z, dx, dy;
      q = 2'((a + 32'h2000_0000) >> 30);
      r = a - {q, 30'd0};
      z = longint'($signed(r));
      x = 652032874;
      y = 0;
      for (int k = 0; k < 30; k++) begin
         dx = y >>> k;
         dy = x >>> k;
         if (z >= 0) begin
            x -= dx; y += dy; z -= ARC_TURN[k];
         end else begin
            x += dx; y -= dy; z += ARC_TURN[k];
         end
      end
      case (q)
         2'd0: begin c = x; s = y; end
         2'd1: begin c = -y; s = x; end
         2'd2: begin c = -x; s = -y; end
         default: begin c = y; s = -x; end
      endcase
   endtask

   function automatic logic [15:0] round_coord(input longint v, input int fb);
      longint r;
      int     sh;
      sh = fb - COORD_FRAC_BITS;
      r = (v + (longint'(1) <<< (sh - 1))) >>> sh;
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return r[15:0];
   endfunction

   function automatic logic [16:0] tex_ratio(input longint unsigned n, input longint unsigned p);
      longint unsigned t;
      t = ((n << 16) + p / 2) / p;
      return (t > 65536) ? 17'd65536 : t[16:0];
   endfunction

   task automatic predict_vertex(input logic [7:0] row, input logic [7:0] col,
                                 output vertex_type v);
      longint unsigned p, i, j, w, top, bot;
      logic [31:0]     ath, aph;
      longint          ct, st, cp, sp;
      p = divisions;
      if (p == 0) p = 1;
      if (p > MAX_PRECISION) p = MAX_PRECISION;
      i = row;
      j = col;
      ath = 32'(((i << 31) + p / 2) / p);
      aph = 32'(((j << 32) + p / 2) / p);
      rotate_turn(ath, ct, st);
      rotate_turn(aph, cp, sp);
      if (st < 0) st = -st;
      v = '0;
      v.pos_x = round_coord(-(cp * st), 60);
      v.pos_y = round_coord(-ct, 30);
      v.pos_z = round_coord(sp * st, 60);
      v.tex_u = tex_ratio(j, p);
      v.tex_v = tex_ratio(i, p);
      if (i < p && j < p) begin
         w = p + 1;
         top = i * w + j;
         bot = (i + 1) * w + j;
         v.a0 = top[15:0];
         v.a1 = 16'(top + 1);
         v.a2 = bot[15:0];
         v.b0 = 16'(top + 1);
         v.b1 = 16'(bot + 1);
         v.b2 = bot[15:0];
         v.cell_valid = 1'b1;
      end
   endtask

   always @(posedge clock) begin
      vertex_type want, got;
      if (reset) begin
         divisions <= PRECISION_RESET;
      end else begin
         if (csr_valid && csr_ready) divisions <= csr_precision;
         if (req_valid && req_ready) begin
            predict_vertex(req_row, req_column, want);
            vertex_due = {vertex_due, want};
         end
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_pos_x, rsp_pos_y, rsp_pos_z, rsp_tex_u, rsp_tex_v,
                    rsp_tri_a0, rsp_tri_a1, rsp_tri_a2, rsp_tri_b0, rsp_tri_b1,
                    rsp_tri_b2, rsp_cell_valid};
            checked <= checked + 1;
            if (vertex_due.size() == 0) begin
               if (errors < 10) $display("unexpected transaction on rsp_ at %0t", $realtime);
               errors <= errors + 1;
            end else begin
               want = vertex_due.pop_front();
               if (got !== want) begin
                  if (errors < 10)
                     $display({"mismatch: exp xyz %0d %0d %0d uv %0d %0d ",
                               "tri %0d %0d %0d %0d %0d %0d c %0d | got xyz %0d %0d %0d ",
                               "uv %0d %0d tri %0d %0d %0d %0d %0d %0d c %0d"},
                              $signed(want.pos_x), $signed(want.pos_y), $signed(want.pos_z),
                              want.tex_u, want.tex_v, want.a0, want.a1, want.a2,
                              want.b0, want.b1, want.b2, want.cell_valid,
                              $signed(got.pos_x), $signed(got.pos_y), $signed(got.pos_z),
                              got.tex_u, got.tex_v, got.a0, got.a1, got.a2,
                              got.b0, got.b1, got.b2, got.cell_valid);
                  errors <= errors + 1;
               end
            end
         end
      end
   end

   initial begin
      errors = 0;
      checked = 0;
   end

   always @(posedge clock) pending <= vertex_due.size();

endmodule

// ----- tb/uv_sphere_vertex_generator_core_tb.sv -----
`timescale 1ns / 100ps

module uv_sphere_vertex_generator_core_tb;
   import svg_pkg::*;

   logic        clock, reset;
   logic        req_valid, req_ready;
   logic [7:0]  req_row, req_column;
   logic        rsp_valid, rsp_ready;
   logic signed [15:0] rsp_pos_x, rsp_pos_y, rsp_pos_z;
   logic [16:0] rsp_tex_u, rsp_tex_v;
   logic [15:0] rsp_tri_a0, rsp_tri_a1, rsp_tri_a2, rsp_tri_b0, rsp_tri_b1, rsp_tri_b2;
   logic        rsp_cell_valid;
   logic        csr_valid, csr_ready;
   logic [7:0]  csr_precision;
   int          errors, pending, checked;
   int          idle_cycles;
   int          sent;
   bit          long_hold;
   bit          no_idle;
   logic [7:0]  eff;
   logic [7:0]  settings[12];

   uv_sphere_vertex_generator_core dut (.*);

   sphere_vertex_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= 5000) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      int stall;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (long_hold) begin
            @(negedge clock);
            rsp_ready <= 1'b0;
            repeat (600) @(negedge clock);
            long_hold = 1'b0;
         end
         stall = no_idle ? 0 : $urandom_range(0, 8);
         repeat (stall) begin
            @(negedge clock);
            rsp_ready <= 1'b0;
         end
         @(negedge clock);
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   task automatic send_point(input logic [7:0] r, input logic [7:0] c);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 8);
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid  <= 1'b1;
      req_row    <= r;
      req_column <= c;
      do @(posedge clock); while (!req_ready);
      sent++;
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0 || checker_i.vertex_due.size() != 0);
      repeat (80) @(posedge clock);
   endtask

   task automatic write_precision(input logic [7:0] v);
      drain();
      @(negedge clock);
      csr_valid     <= 1'b1;
      csr_precision <= v;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      eff = (v == 0) ? 8'd1 : v;
   endtask

   initial begin
      settings = '{8'd255, 8'd1, 8'd0, 8'd2, 8'd3, 8'd7,
                   8'd48, 8'd100, 8'd17, 8'd200, 8'd255, 8'd5};
      reset = 1'b1;
      req_valid = 1'b0;
      req_row = '0;
      req_column = '0;
      csr_valid = 1'b0;
      csr_precision = '0;
      long_hold = 1'b0;
      no_idle = 1'b0;
      sent = 0;
      eff = PRECISION_RESET;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_point(8'd0, 8'd0);
      send_point(8'd48, 8'd48);
      send_point(8'd24, 8'd12);
      send_point(8'd47, 8'd47);
      send_point(8'd48, 8'd0);
      send_point(8'd0, 8'd48);
      send_point(8'd255, 8'd255);
      send_point(8'd49, 8'd0);
      send_point(8'd12, 8'd36);
      send_point(8'd36, 8'd12);
      send_point(8'd0, 8'd24);
      send_point(8'd24, 8'd0);
      send_point(8'd255, 8'd0);
      send_point(8'd0, 8'd255);
      send_point(8'd1, 8'd1);
      send_point(8'd96, 8'd96);

      foreach (settings[k]) begin
         write_precision(settings[k]);
         if (k == 0) begin
            send_point(8'd254, 8'd254);
            send_point(8'd254, 8'd255);
            send_point(8'd255, 8'd254);
         end
         no_idle = (k == 4 || k == 9);
         for (int n = 0; n < 150; n++) begin
            if (k == 2 && n == 20) long_hold = 1'b1;
            if ($urandom_range(0, 99) < 85)
               send_point(8'($urandom_range(0, eff)), 8'($urandom_range(0, eff)));
            else
               send_point(8'($urandom), 8'($urandom));
         end
         no_idle = 1'b0;
      end

      drain();
      $display("%0d grid points sent, %0d results checked over 13 precision settings",
               sent, checked);
      $display("incl. extremes 0/1/255, out-of-range indices, long rsp_ stall");
      if (errors == 0 && pending == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

// ----- files.f -----
rtl/core/svg_pkg.sv
rtl/core/svg_div_cell.sv
rtl/core/svg_cordic_cell.sv
rtl/core/uv_sphere_vertex_generator_core.sv
tb/sphere_vertex_checker.sv
tb/uv_sphere_vertex_generator_core_tb.sv
